[rtl/bbc_pkg.sv]
// ---------------------------------------------------------------------------
// Buffer cache controller package
// Function codes, disk commands and status codes shared by the block.
// ---------------------------------------------------------------------------
package bbc_pkg;

  typedef enum logic [2:0] {
    FN_GET     = 3'd0,
    FN_READ    = 3'd1,
    FN_RELEASE = 3'd2,
    FN_DWRITE  = 3'd3,
    FN_WRITE   = 3'd4,
    FN_FLUSH   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    DOP_NONE  = 2'd0,
    DOP_READ  = 2'd1,
    DOP_WRITE = 2'd2
  } disk_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BUSY     = 2'd2,
    ST_NOT_HELD = 2'd3
  } status_e;

  localparam int unsigned MaxResults = 16;

endpackage

[rtl/bbc_tag_cmp.sv]
// ---------------------------------------------------------------------------
// Buffer cache tag comparator
// The shared compare unit used by the sequencer for one list entry a cycle.
// ---------------------------------------------------------------------------
module bbc_tag_cmp #(
  parameter int unsigned BlockBits = 24
) (
  input  logic [BlockBits-1:0] tag_i,
  input  logic                 tag_valid_i,
  input  logic [BlockBits-1:0] key_i,
  output logic                 match_o
);

  assign match_o = tag_valid_i && (tag_i == key_i);

endmodule

[rtl/block_buffer_cache_lru_top.sv]
// ---------------------------------------------------------------------------
// Buffer cache tag and replacement controller
// Keeps tags and flags for each buffer, a least-recently-released free list
// and an assignment list; serves get, read, release, dwrite, write and flush.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// in        input      in_valid/stall    func, block_number, buffer_index
// out       output     out_valid/stall   buffer_index_out .. last
//
// An item is decoded, a lookup or flush then walks the assignment list
// (at most NUM_BUFFERS entries), and each result is then presented on out.
// A lookup that misses and a flush with nothing to write also handle the end
// of the list, and a miss that takes a buffer passes through a grant state.
// Reset leaves every buffer free in index order and no tag.
// An output stall holds the result and the sequencer in place.
module block_buffer_cache_lru_top
  import bbc_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 16,
  parameter int unsigned BLOCK_BITS  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [23:0] block_number_i,
  input  logic [3:0]  buffer_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  buffer_index_out_o,
  output logic        hit_o,
  output logic [1:0]  disk_op_o,
  output logic [23:0] disk_block_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int unsigned IW = $clog2(NUM_BUFFERS + 1);
  localparam int unsigned XW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned CW = $clog2(NUM_BUFFERS + 1);
  localparam int unsigned KW = $clog2(MaxResults + 1);
  localparam logic [IW-1:0] NIL = IW'(NUM_BUFFERS);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_WALK, S_GRANT, S_FLUSH, S_OUT
  } state_e;

  state_e state_q;
  logic [2:0] func_q;
  logic [BLOCK_BITS-1:0] key_q;
  logic [3:0] bidx_q;

  logic [BLOCK_BITS-1:0] tag_q [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] tv_q, busy_q, dv_q, dirty_q;
  logic [IW-1:0] fnext_q [NUM_BUFFERS];
  logic [IW-1:0] fprev_q [NUM_BUFFERS];
  logic [IW-1:0] fhead_q, ftail_q;
  logic [IW-1:0] anext_q [NUM_BUFFERS];
  logic [IW-1:0] ahead_q;

  logic [IW-1:0] cur_q;
  logic [CW-1:0] cnt_q;
  logic [KW-1:0] kout_q;
  logic          pend_grant_q;

  logic [3:0]  o_idx_q;
  logic        o_hit_q, o_last_q;
  logic [1:0]  o_op_q, o_st_q;
  logic [23:0] o_blk_q;

  logic [XW-1:0] cx;
  logic match;
  assign cx = cur_q[XW-1:0];

  bbc_tag_cmp #(.BlockBits(BLOCK_BITS)) u_cmp (
    .tag_i      (tag_q[cx]),
    .tag_valid_i(tv_q[cx]),
    .key_i      (key_q),
    .match_o    (match)
  );

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = (state_q == S_OUT);
  assign buffer_index_out_o = o_idx_q;
  assign hit_o              = o_hit_q;
  assign disk_op_o          = o_op_q;
  assign disk_block_o       = o_blk_q;
  assign status_o           = o_st_q;
  assign last_o             = o_last_q;

  logic [XW-1:0] bx;
  logic held;
  assign bx   = bidx_q[XW-1:0];
  assign held = ({28'd0, bidx_q} < 32'(NUM_BUFFERS)) && busy_q[bx];

  function automatic logic [23:0] blk24(input logic [BLOCK_BITS-1:0] b);
    logic [31:0] w;
    w = 32'(b);
    return w[23:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [IW-1:0] p, n;
    logic [XW-1:0] hx;
    logic [NUM_BUFFERS-1:0] rest;
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tv_q <= '0; busy_q <= '0; dv_q <= '0; dirty_q <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        fnext_q[i] <= IW'(i + 1);
        fprev_q[i] <= (i == 0) ? NIL : IW'(i - 1);
        anext_q[i] <= NIL;
      end
      fhead_q <= '0; ftail_q <= IW'(NUM_BUFFERS - 1); ahead_q <= NIL;
      cur_q <= '0; cnt_q <= '0; kout_q <= '0; pend_grant_q <= 1'b0;
      o_idx_q <= '0; o_hit_q <= 1'b0; o_op_q <= '0; o_blk_q <= '0;
      o_st_q <= '0; o_last_q <= 1'b0;
    end else begin
      p = '0; n = '0; hx = '0; rest = '0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q <= func_i;
            key_q  <= BLOCK_BITS'(block_number_i);
            bidx_q <= buffer_index_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          o_idx_q <= bidx_q; o_hit_q <= 1'b0; o_op_q <= DOP_NONE;
          o_blk_q <= '0; o_st_q <= ST_OK; o_last_q <= 1'b1;
          cur_q <= ahead_q; cnt_q <= '0; kout_q <= '0;
          unique case (func_q) inside
            FN_GET, FN_READ: state_q <= S_WALK;
            FN_FLUSH: state_q <= S_FLUSH;
            FN_RELEASE, FN_DWRITE: begin
              if (!held) o_st_q <= ST_NOT_HELD;
              else begin
                if (func_q == FN_DWRITE) begin
                  dirty_q[bx] <= 1'b1; dv_q[bx] <= 1'b1;
                end
                busy_q[bx] <= 1'b0;
                fnext_q[bx] <= NIL; fprev_q[bx] <= ftail_q;
                if (ftail_q >= NIL) fhead_q <= IW'(bidx_q);
                else fnext_q[ftail_q[XW-1:0]] <= IW'(bidx_q);
                ftail_q <= IW'(bidx_q);
              end
              state_q <= S_OUT;
            end
            FN_WRITE: begin
              if (!held) o_st_q <= ST_NOT_HELD;
              else begin
                dirty_q[bx] <= 1'b0; dv_q[bx] <= 1'b1;
                o_op_q <= DOP_WRITE; o_blk_q <= blk24(tag_q[bx]);
              end
              state_q <= S_OUT;
            end
            default: begin
              o_idx_q <= '0;
              state_q <= S_OUT;
            end
          endcase
        end
        S_WALK: begin
          if (cur_q >= NIL || cnt_q == CW'(NUM_BUFFERS)) begin
            hx = fhead_q[XW-1:0];
            if (fhead_q >= NIL) begin
              o_idx_q <= '0; o_st_q <= ST_NO_FREE; state_q <= S_OUT;
            end else begin
              p = fprev_q[hx]; n = fnext_q[hx];
              fhead_q <= n;
              if (n >= NIL) ftail_q <= p; else fprev_q[n[XW-1:0]] <= p;
              fnext_q[hx] <= NIL; fprev_q[hx] <= NIL;
              busy_q[hx] <= 1'b1;
              cur_q <= fhead_q;
              if (dirty_q[hx] && tv_q[hx]) begin
                o_idx_q <= 4'(fhead_q); o_op_q <= DOP_WRITE;
                o_blk_q <= blk24(tag_q[hx]); o_last_q <= 1'b0;
                pend_grant_q <= 1'b1;
                state_q <= S_OUT;
              end else state_q <= S_GRANT;
            end
          end else if (match) begin
            o_idx_q <= 4'(cur_q); o_hit_q <= 1'b1;
            if (busy_q[cx]) o_st_q <= ST_BUSY;
            else begin
              p = fprev_q[cx]; n = fnext_q[cx];
              if (p >= NIL) fhead_q <= n; else fnext_q[p[XW-1:0]] <= n;
              if (n >= NIL) ftail_q <= p; else fprev_q[n[XW-1:0]] <= p;
              fnext_q[cx] <= NIL; fprev_q[cx] <= NIL;
              busy_q[cx] <= 1'b1;
              if (func_q == FN_READ && !dv_q[cx]) begin
                dv_q[cx] <= 1'b1; o_op_q <= DOP_READ; o_blk_q <= blk24(key_q);
              end
            end
            state_q <= S_OUT;
          end else begin
            cur_q <= anext_q[cx];
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_GRANT: begin
          dirty_q[cx] <= 1'b0;
          dv_q[cx] <= (func_q == FN_READ);
          if (!tv_q[cx]) begin
            tv_q[cx] <= 1'b1; anext_q[cx] <= ahead_q; ahead_q <= cur_q;
          end
          tag_q[cx] <= key_q;
          o_idx_q <= 4'(cur_q); o_hit_q <= 1'b0; o_st_q <= ST_OK;
          o_last_q <= 1'b1;
          if (func_q == FN_READ) begin
            o_op_q <= DOP_READ; o_blk_q <= blk24(key_q);
          end else begin
            o_op_q <= DOP_NONE; o_blk_q <= '0;
          end
          state_q <= S_OUT;
        end
        S_FLUSH: begin
          if (cur_q >= NIL || cnt_q == CW'(NUM_BUFFERS)
              || kout_q == KW'(MaxResults)) begin
            if (kout_q == '0) begin
              o_idx_q <= '0; o_op_q <= DOP_NONE; o_blk_q <= '0;
              o_last_q <= 1'b1; state_q <= S_OUT;
            end else state_q <= S_IDLE;
          end else begin
            cur_q <= anext_q[cx];
            cnt_q <= cnt_q + 1'b1;
            if (dirty_q[cx] && tv_q[cx]) begin
              rest = dirty_q & tv_q & ~(NUM_BUFFERS'(1) << cx);
              dirty_q[cx] <= 1'b0; dv_q[cx] <= 1'b1;
              o_idx_q <= 4'(cur_q); o_op_q <= DOP_WRITE;
              o_blk_q <= blk24(tag_q[cx]);
              o_last_q <= (rest == '0) || (kout_q == KW'(MaxResults - 1));
              kout_q <= kout_q + 1'b1;
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            if (pend_grant_q) begin
              pend_grant_q <= 1'b0; state_q <= S_GRANT;
            end else if (func_q == FN_FLUSH && !o_last_q) begin
              state_q <= S_FLUSH;
            end else state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/bbc_checker.sv]
// ---------------------------------------------------------------------------
// Buffer cache controller port checker
// Watches the top level's ports and checks the handshake and result codes.
// ---------------------------------------------------------------------------
module bbc_checker
  import bbc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  disk_op_o,
  input logic [1:0]  status_o,
  input logic [23:0] disk_block_o,
  input logic        hit_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(disk_block_o))
    else $error("stalled result changed");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_op_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> disk_op_o != 2'd3)
    else $error("unknown disk command");

  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> disk_op_o == DOP_NONE)
    else $error("disk command with failure status");

  a_busy_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BUSY |-> hit_o)
    else $error("busy status without hit");

endmodule

bind block_buffer_cache_lru_top bbc_checker u_bbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .disk_op_o   (disk_op_o),
  .status_o    (status_o),
  .disk_block_o(disk_block_o),
  .hit_o       (hit_o)
);
